// ===== src/assert_macros.svh =====
// Assertion macros shared by the rank engine RTL.
// Every macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/rae_pkg.sv =====
// Package for the rank assignment engine: widths, defaults, FSM state type
// and the control struct between the sequencer and the rank counter.
// No dependencies.
package rae_pkg;

    localparam int DATA_W        = 32;
    localparam int RANK_W        = 7;
    localparam int MAX_ITEMS_DEF = 64;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_PIVOT,
        ST_SCAN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
    } rank_ctl_t;

endpackage

// ===== src/rae_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rae_rank.sv =====
// Shared compare unit and rank counter: one stored value per cycle against the pivot.
// Depends on rae_pkg.
module rae_rank #(
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rae_pkg::rank_ctl_t         ctl,
    input  logic [rae_pkg::DATA_W-1:0] w,
    input  logic [rae_pkg::DATA_W-1:0] v,
    input  logic [IDX_W-1:0]           j,
    input  logic [IDX_W-1:0]           k,
    output logic [CNT_W-1:0]           rank
);

    logic             hit;
    logic [CNT_W-1:0] rank_reg;
    logic [CNT_W-1:0] rank_next;

    // w ranks ahead of v: smaller, or equal and loaded earlier
    assign hit = ($signed(w) < $signed(v)) || ((w == v) && (j < k));

    always_comb
    begin
        rank_next = rank_reg;
        if (ctl.clear)
        begin
            rank_next = CNT_W'(1);
        end
        else if (ctl.step && hit)
        begin
            rank_next = rank_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= CNT_W'(1);
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

    assign rank = rank_reg;

endmodule

// ===== src/rank_assignment_engine_unit.sv =====
// Rank assignment engine top level: sequencer, value RAM and rank counter.
// Depends on rae_pkg, rae_ram, rae_rank and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready, value, last) loads a list of signed
//   32-bit values, one per transfer; last closes the list. Values beyond
//   MAX_ITEMS are dropped and flag every result of that list with overflow.
//   Output channel (out_valid/out_ready, rank, last_res, overflow) then
//   returns one result per stored value, in load order; last_res marks the
//   final one. Equal values rank by load order.
//   in_ready stays high while a list loads. After the closing transfer,
//   each result takes one RAM read for the pivot (ST_FETCH, ST_PIVOT),
//   then a scan of the list through the single comparator, one stored
//   value per cycle, and is then offered in ST_OUT.
//   in_ready is low from the closing transfer until the last result is
//   taken. A stalled receiver holds the current result stable.
//   Reset clears the sequencer, item count and overflow flag; no clearing
//   pass is run, the RAM is only read at entries of the current list.
`include "assert_macros.svh"

module rank_assignment_engine_unit #(
    parameter int MAX_ITEMS = rae_pkg::MAX_ITEMS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [31:0]         value,
    input  logic                       last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rae_pkg::RANK_W-1:0] rank,
    output logic                       last_res,
    output logic                       overflow
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    rae_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [rae_pkg::DATA_W-1:0] v_reg, v_next;

    logic                       ram_we;
    logic [IDX_W-1:0]           ram_raddr;
    logic [rae_pkg::DATA_W-1:0] ram_rdata;
    rae_pkg::rank_ctl_t         rank_ctl;
    logic [CNT_W-1:0]           rank_cnt;

    logic full;
    logic j_last;
    logic k_last;

    assign full   = (count_reg == CNT_W'(MAX_ITEMS));
    assign j_last = ((CNT_W'(j_reg) + CNT_W'(1)) == count_reg);
    assign k_last = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);

    rae_ram #(
        .WIDTH(rae_pkg::DATA_W),
        .DEPTH(MAX_ITEMS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[IDX_W-1:0]),
        .wdata(value),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    rae_rank #(
        .IDX_W(IDX_W),
        .CNT_W(CNT_W)
    ) u_rank (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (rank_ctl),
        .w    (ram_rdata),
        .v    (v_reg),
        .j    (j_reg),
        .k    (k_reg),
        .rank (rank_cnt)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        v_next     = v_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        ram_we     = 1'b0;
        ram_raddr  = k_reg;
        rank_ctl   = '0;
        case (state_reg)
            rae_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last)
                    begin
                        k_next     = '0;
                        state_next = rae_pkg::ST_FETCH;
                    end
                end
            end
            rae_pkg::ST_FETCH:
            begin
                ram_raddr  = k_reg;
                state_next = rae_pkg::ST_PIVOT;
            end
            rae_pkg::ST_PIVOT:
            begin
                v_next         = ram_rdata;
                ram_raddr      = '0;
                j_next         = '0;
                rank_ctl.clear = 1'b1;
                state_next     = rae_pkg::ST_SCAN;
            end
            rae_pkg::ST_SCAN:
            begin
                rank_ctl.step = 1'b1;
                if (j_last)
                begin
                    ram_raddr  = '0;
                    state_next = rae_pkg::ST_OUT;
                end
                else
                begin
                    ram_raddr = j_reg + IDX_W'(1);
                    j_next    = j_reg + IDX_W'(1);
                end
            end
            rae_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (k_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = rae_pkg::ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = rae_pkg::ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = rae_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rae_pkg::ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            k_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    assign rank     = rae_pkg::RANK_W'(rank_cnt);
    assign last_res = k_last;
    assign overflow = ovf_reg;

    `ASSERT_IMPL(a_no_load_while_out, out_valid, !in_ready)
    `ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_ITEMS))
    `ASSERT_IMPL(a_rank_range, out_valid, (rank_cnt != '0) && (rank_cnt <= count_reg))
    `ASSERT_NEXT(a_list_cleared, out_valid && out_ready && last_res, (count_reg == '0) && !ovf_reg && in_ready)

endmodule

// ===== sim/rank_assignment_engine_checker.sv =====
// Checker for rank_assignment_engine_unit: watches both channels, predicts
// the rank of every loaded value and compares each result transfer in order.
// Depends on rae_pkg.
module rank_assignment_engine_checker #(
    parameter int MAX_ITEMS = rae_pkg::MAX_ITEMS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic signed [31:0]         value,
    input  logic                       last,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [rae_pkg::RANK_W-1:0] rank,
    input  logic                       last_res,
    input  logic                       overflow,
    output int                         errors,
    output int                         pending,
    output int                         ranks_checked
);

    typedef struct packed {
        logic [rae_pkg::RANK_W-1:0] rank;
        logic                       last_res;
        logic                       overflow;
    } rank_result_t;

    logic signed [31:0] list_values[$];
    logic               list_dropped = 1'b0;
    rank_result_t       expected_ranks[$];
    int                 error_total = 0;
    int                 checked_total = 0;

    // 1 + entries that are smaller, or equal and loaded earlier
    function automatic logic [rae_pkg::RANK_W-1:0] rank_of_entry(input int pos);
        int r;
        r = 1;
        foreach (list_values[j]) begin
            if (list_values[j] < list_values[pos] ||
                (list_values[j] == list_values[pos] && j < pos))
                r++;
        end
        return r[rae_pkg::RANK_W-1:0];
    endfunction

    task automatic note_error(input string what);
        error_total++;
        if (error_total <= 10)
            $display("[%0t] rank mismatch: %s", $realtime, what);
    endtask

    always @(posedge clk) begin : watch
        rank_result_t want;
        if (!rst_n) begin
            list_values.delete();
            expected_ranks.delete();
            list_dropped = 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                checked_total++;
                if (expected_ranks.size() == 0) begin
                    note_error($sformatf("unexpected result rank=%0d last_res=%0b overflow=%0b",
                                         rank, last_res, overflow));
                end
                else begin
                    want = expected_ranks.pop_front();
                    if (rank !== want.rank || last_res !== want.last_res ||
                        overflow !== want.overflow)
                        note_error($sformatf({"result %0d: expected rank=%0d last_res=%0b ",
                                              "overflow=%0b, got rank=%0d last_res=%0b ",
                                              "overflow=%0b"},
                                             checked_total, want.rank, want.last_res,
                                             want.overflow, rank, last_res, overflow));
                end
            end
            if (in_valid && in_ready) begin
                if (list_values.size() < MAX_ITEMS)
                    list_values.push_back(value);
                else
                    list_dropped = 1'b1;
                if (last) begin
                    foreach (list_values[k]) begin
                        want.rank     = rank_of_entry(k);
                        want.last_res = (k == list_values.size() - 1);
                        want.overflow = list_dropped;
                        expected_ranks.push_back(want);
                    end
                    list_values.delete();
                    list_dropped = 1'b0;
                end
            end
        end
        errors        <= error_total;
        pending       <= expected_ranks.size();
        ranks_checked <= checked_total;
    end

endmodule

// ===== sim/rank_assignment_engine_unit_test.sv =====
// Testbench top for rank_assignment_engine_unit: clock, reset, list stimulus,
// receiver stalls and the verdict. Depends on rae_pkg, the RTL and
// rank_assignment_engine_checker.
module rank_assignment_engine_unit_test;

    localparam int LIST_CAP     = rae_pkg::MAX_ITEMS_DEF;
    localparam int RANDOM_ITEMS = 380;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_FROM   = 4000;
    localparam int QUIET_TO     = 12000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [31:0]         value = '0;
    logic                       last = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [rae_pkg::RANK_W-1:0] rank;
    logic                       last_res;
    logic                       overflow;

    logic                hold_off = 1'b0;
    logic                quiet;
    int                  cycle_count = 0;
    int                  errors;
    int                  pending;
    int                  ranks_checked;
    int                  lists_sent = 0;
    int                  values_sent = 0;
    int                  lists_overflowed = 0;

    rank_assignment_engine_unit #(
        .MAX_ITEMS(LIST_CAP)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value    (value),
        .last     (last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .rank     (rank),
        .last_res (last_res),
        .overflow (overflow)
    );

    rank_assignment_engine_checker #(
        .MAX_ITEMS(LIST_CAP)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rank         (rank),
        .last_res     (last_res),
        .overflow     (overflow),
        .errors       (errors),
        .pending      (pending),
        .ranks_checked(ranks_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("** rank_assignment_engine_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else if (quiet)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 26);
    end

    // long receiver stall while lists keep coming, so the input backs up
    initial
    begin
        wait (ranks_checked >= 30);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic send_item(input logic signed [31:0] v, input logic l);
        while (!quiet && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= l;
        do
            @(posedge clk);
        while (!in_ready);
        values_sent++;
        if (l)
            lists_sent++;
    endtask

    function automatic logic signed [31:0] pick_value(input int unsigned spread);
        logic signed [31:0] v;
        case ($urandom_range(7))
            0: v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            1, 2, 3: v = int'($urandom_range(spread)) - int'(spread / 2);
            default: v = $urandom();
        endcase
        return v;
    endfunction

    initial
    begin : stimulus
        int list_idx;
        int len;
        int random_sent;
        int unsigned spread;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single value
        send_item(32'sd0, 1'b1);
        // field extremes
        send_item(32'sh7fffffff, 1'b0);
        send_item(32'sh80000000, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sd1, 1'b1);
        // all equal: ranks follow load order
        send_item(32'sd5, 1'b0);
        send_item(32'sd5, 1'b0);
        send_item(32'sd5, 1'b1);
        // repeated extremes
        send_item(32'sh80000000, 1'b0);
        send_item(32'sd7, 1'b0);
        send_item(32'sh80000000, 1'b0);
        send_item(32'sh7fffffff, 1'b0);
        send_item(32'sh7fffffff, 1'b1);
        // descending
        send_item(32'sd4, 1'b0);
        send_item(32'sd3, 1'b0);
        send_item(32'sd2, 1'b0);
        send_item(-32'sd2, 1'b1);

        list_idx    = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (list_idx == 3)
                len = LIST_CAP;
            else if (list_idx == 9)
                len = LIST_CAP + 1;
            else if (list_idx == 16)
                len = LIST_CAP + $urandom_range(2, 6);
            else if ($urandom_range(9) == 0)
                len = $urandom_range(11, 30);
            else
                len = $urandom_range(1, 10);
            spread = $urandom_range(1) ? 4 : 1000;
            for (int k = 0; k < len; k++)
                send_item(pick_value(spread), k == len - 1);
            if (len > LIST_CAP)
                lists_overflowed++;
            random_sent += len;
            list_idx++;
        end
        in_valid <= 1'b0;
        @(posedge clk);

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d lists, %0d values (%0d lists past capacity), %0d ranks checked.",
                 lists_sent, values_sent, lists_overflowed, ranks_checked);
        $display("Included extremes, ties, a full list and a %0d-cycle receiver stall.",
                 HOLD_CYCLES);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (errors == 0 && pending == 0)
            $display("** rank_assignment_engine_unit: PASSED **");
        else
            $display("** rank_assignment_engine_unit: FAILED **");
        $finish;
    end

endmodule
